FILE: hdl/bounded_deque_top_defines.svh
// assertion macros for the bounded deque
// no dependencies; taken in by the files that carry assertions
`ifndef BOUNDED_DEQUE_TOP_DEFINES_SVH
`define BOUNDED_DEQUE_TOP_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, checked outside reset
`define BDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bdq check failed");

// next-cycle implication, checked outside reset
`define BDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bdq check failed");

`else

`define BDQ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/bdq_pkg.sv
// shared types and sizes for the bounded deque
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int CAPACITY  = 128;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int POP_W     = 32;
  localparam int FILL_W    = 8;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_REAR  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_REAR   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // broadcast to every cell of one row
  typedef struct packed {
    logic shift_up;    // take the word of the lower neighbour
    logic shift_down;  // take the word of the upper neighbour
    logic load;        // the cell addressed by slot takes the pushed word
    idx_t slot;
  } cell_ctl_t;

endpackage

FILE: hdl/bdq_cell.sv
// one storage cell of a deque row: holds a word, shifts either way or loads
// depends on bdq_pkg
`timescale 1ns / 1ps

module bdq_cell (
  input  logic              clk,
  input  bdq_pkg::cell_ctl_t ctl,
  input  bdq_pkg::idx_t     cell_idx,
  input  bdq_pkg::word_t    push_word,
  input  bdq_pkg::word_t    from_below,
  input  bdq_pkg::word_t    from_above,
  output bdq_pkg::word_t    word
);

  bdq_pkg::word_t data_r;
  bdq_pkg::word_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.load && (ctl.slot == cell_idx)) begin
      data_nxt = push_word;
    end else if (ctl.shift_up) begin
      data_nxt = from_below;
    end else if (ctl.shift_down) begin
      data_nxt = from_above;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign word = data_r;

endmodule

FILE: hdl/bdq_row.sv
// a row of deque cells linked to their neighbours, words enter at either end
// depends on bdq_pkg and bdq_cell
`timescale 1ns / 1ps

module bdq_row (
  input  logic               clk,
  input  bdq_pkg::cell_ctl_t ctl,
  input  bdq_pkg::word_t     push_word,
  output bdq_pkg::word_t     low_word,
  output bdq_pkg::word_t     high_word
);

  bdq_pkg::word_t cell_word [bdq_pkg::CAPACITY];

  for (genvar i = 0; i < bdq_pkg::CAPACITY; i++) begin : g_cell
    bdq_pkg::word_t below_w;
    bdq_pkg::word_t above_w;

    // the end cells take the pushed word from outside the row
    if (i == 0) begin : g_low_end
      assign below_w = push_word;
    end else begin : g_low_link
      assign below_w = cell_word[i-1];
    end

    if (i == bdq_pkg::CAPACITY - 1) begin : g_high_end
      assign above_w = push_word;
    end else begin : g_high_link
      assign above_w = cell_word[i+1];
    end

    bdq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .cell_idx  (bdq_pkg::IDX_W'(i)),
      .push_word (push_word),
      .from_below(below_w),
      .from_above(above_w),
      .word      (cell_word[i])
    );
  end

  assign low_word  = cell_word[0];
  assign high_word = cell_word[bdq_pkg::CAPACITY-1];

endmodule

FILE: hdl/bounded_deque_top.sv
// bounded deque top level: request decode, fill count and result register
// depends on bdq_pkg, bdq_row and bounded_deque_top_defines.svh
`timescale 1ns / 1ps

// Fixed-capacity double-ended queue of CAPACITY signed words. One request is
// taken per clock while in_stall is low, and its result (popped word, status,
// new fill count) appears in the output register on the next cycle; in_stall
// rises only while that register holds an untaken result and the output side
// stalls. Storage is two rows of shifting cells holding the same words: the
// front row keeps the front word in its first cell, the rear row keeps the
// rear word in its last cell, so both pops read a fixed cell. Refused requests
// (push when full, pop when empty) leave the store and the fill count
// untouched and return a zero popped word.

`include "bounded_deque_top_defines.svh"

module bounded_deque_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_push_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pop_value,
  output logic [1:0]         out_status,
  output logic [7:0]         out_fill_count
);

  localparam bdq_pkg::idx_t LAST_IDX = bdq_pkg::IDX_W'(bdq_pkg::CAPACITY - 1);
  localparam bdq_pkg::cnt_t FULL_CNT = bdq_pkg::CNT_W'(bdq_pkg::CAPACITY);

  bdq_pkg::cnt_t             count_r;
  bdq_pkg::cnt_t             count_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic [bdq_pkg::POP_W-1:0] pop_value_r;
  logic [bdq_pkg::POP_W-1:0] pop_value_nxt;
  bdq_pkg::status_t          status_r;
  bdq_pkg::status_t          status_nxt;

  bdq_pkg::mode_t     mode;
  bdq_pkg::word_t     push_word;
  bdq_pkg::word_t     front_word;
  bdq_pkg::word_t     rear_word;
  bdq_pkg::cell_ctl_t front_ctl;
  bdq_pkg::cell_ctl_t rear_ctl;
  logic               acc;
  logic               full;
  logic               empty;

  assign in_stall  = out_valid_r && out_stall;
  assign acc       = in_valid && !in_stall;
  assign mode      = bdq_pkg::mode_t'(in_mode);
  assign push_word = bdq_pkg::WORD_BITS'($unsigned(in_push_value));
  assign full      = (count_r == FULL_CNT);
  assign empty     = (count_r == '0);

  always_comb begin
    count_nxt     = count_r;
    pop_value_nxt = '0;
    status_nxt    = bdq_pkg::STATUS_OK;
    front_ctl     = '{shift_up: 1'b0, shift_down: 1'b0, load: 1'b0,
                      slot: bdq_pkg::IDX_W'(count_r)};
    rear_ctl      = '{shift_up: 1'b0, shift_down: 1'b0, load: 1'b0,
                      slot: LAST_IDX - bdq_pkg::IDX_W'(count_r)};
    case (mode)
      bdq_pkg::MODE_PUSH_FRONT: begin
        if (full) begin
          status_nxt = bdq_pkg::STATUS_FULL;
        end else begin
          front_ctl.shift_up = acc;
          rear_ctl.load      = acc;
          count_nxt          = count_r + 1'b1;
        end
      end
      bdq_pkg::MODE_PUSH_REAR: begin
        if (full) begin
          status_nxt = bdq_pkg::STATUS_FULL;
        end else begin
          front_ctl.load      = acc;
          rear_ctl.shift_down = acc;
          count_nxt           = count_r + 1'b1;
        end
      end
      bdq_pkg::MODE_POP_FRONT: begin
        if (empty) begin
          status_nxt = bdq_pkg::STATUS_EMPTY;
        end else begin
          // rear row keeps its words, the count alone drops the front one
          front_ctl.shift_down = acc;
          pop_value_nxt        = bdq_pkg::POP_W'(front_word);
          count_nxt            = count_r - 1'b1;
        end
      end
      bdq_pkg::MODE_POP_REAR: begin
        if (empty) begin
          status_nxt = bdq_pkg::STATUS_EMPTY;
        end else begin
          rear_ctl.shift_up = acc;
          pop_value_nxt     = bdq_pkg::POP_W'(rear_word);
          count_nxt         = count_r - 1'b1;
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  bdq_row u_front_row (
    .clk      (clk),
    .ctl      (front_ctl),
    .push_word(push_word),
    .low_word (front_word),
    .high_word()
  );

  bdq_row u_rear_row (
    .clk      (clk),
    .ctl      (rear_ctl),
    .push_word(push_word),
    .low_word (),
    .high_word(rear_word)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (acc) begin
        count_r <= count_nxt;
      end
    end
  end

  // result word only moves when a new request is taken
  always_ff @(posedge clk) begin
    if (acc) begin
      pop_value_r <= pop_value_nxt;
      status_r    <= status_nxt;
    end
  end

  logic [bdq_pkg::FILL_W-1:0] fill_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      fill_r <= bdq_pkg::FILL_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pop_value  = $signed(pop_value_r);
  assign out_status     = status_r;
  assign out_fill_count = fill_r;

  `BDQ_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_r <= FULL_CNT)
  `BDQ_ASSERT_NEXT(a_refused_keeps_count, clk, rst_n, acc && (status_nxt != bdq_pkg::STATUS_OK), count_r == $past(count_r))
  `BDQ_ASSERT_NEXT(a_result_follows, clk, rst_n, acc, out_valid_r)
  `BDQ_ASSERT_NOW(a_rows_agree, clk, rst_n, count_r == bdq_pkg::CNT_W'(1), front_word == rear_word)
  `BDQ_ASSERT_NOW(a_full_status, clk, rst_n, out_valid_r && (status_r == bdq_pkg::STATUS_FULL), fill_r == bdq_pkg::FILL_W'(bdq_pkg::CAPACITY))

endmodule

FILE: tb/bounded_deque_top_test.sv
`timescale 1ns / 1ps
// self-checking testbench for bounded_deque_top: directed corner requests, then
// biased random fill/drain phases checked against a circular-store mirror
// depends on bdq_pkg and the bounded_deque_top rtl

typedef struct {
  logic [31:0]      pop_value;
  bdq_pkg::status_t status;
  logic [7:0]       fill_count;
} deque_result_t;

// circular store with head index and count, plus the results still owed
class deque_mirror;
  bdq_pkg::word_t store [bdq_pkg::CAPACITY];
  int             head;
  int             held;
  deque_result_t  pending_results [$];
  int             errors;
  int             checked;
  int             pushes;
  int             pops;
  int             full_refusals;
  int             empty_refusals;
  int             peak_fill;

  function new();
    head           = 0;
    held           = 0;
    errors         = 0;
    checked        = 0;
    pushes         = 0;
    pops           = 0;
    full_refusals  = 0;
    empty_refusals = 0;
    peak_fill      = 0;
  endfunction

  function void note_request(bdq_pkg::mode_t mode, bdq_pkg::word_t value);
    deque_result_t r;
    int            slot;
    r.pop_value = '0;
    r.status    = bdq_pkg::STATUS_OK;
    if (mode == bdq_pkg::MODE_PUSH_FRONT || mode == bdq_pkg::MODE_PUSH_REAR) begin
      if (held >= bdq_pkg::CAPACITY) begin
        r.status = bdq_pkg::STATUS_FULL;
        full_refusals++;
      end else begin
        if (mode == bdq_pkg::MODE_PUSH_FRONT) begin
          head = (head + bdq_pkg::CAPACITY - 1) % bdq_pkg::CAPACITY;
          slot = head;
        end else begin
          slot = (head + held) % bdq_pkg::CAPACITY;
        end
        store[slot] = value;
        held++;
        pushes++;
      end
    end else begin
      if (held == 0) begin
        r.status = bdq_pkg::STATUS_EMPTY;
        empty_refusals++;
      end else begin
        if (mode == bdq_pkg::MODE_POP_FRONT) begin
          slot = head;
          head = (head + 1) % bdq_pkg::CAPACITY;
        end else begin
          slot = (head + held - 1) % bdq_pkg::CAPACITY;
        end
        r.pop_value = store[slot];
        held--;
        pops++;
      end
    end
    if (held > peak_fill) peak_fill = held;
    r.fill_count = 8'(held);
    pending_results.push_back(r);
  endfunction

  task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
  endtask

  task check_result(logic [31:0] pop_value, logic [1:0] status, logic [7:0] fill);
    deque_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("word with none pending", pop_value, '0);
      return;
    end
    want = pending_results.pop_front();
    checked++;
    if (pop_value !== want.pop_value) report_mismatch("pop_value", pop_value, want.pop_value);
    if (status !== want.status) report_mismatch("status", 32'(status), 32'(want.status));
    if (fill !== want.fill_count) report_mismatch("fill_count", 32'(fill), 32'(want.fill_count));
  endtask
endclass

module bounded_deque_top_test;

  localparam int CLK_PERIOD       = 12;
  localparam int RESET_CYCLES     = 5;
  localparam int RANDOM_WORDS     = 1500;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 8;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_mode;
  logic signed [31:0] in_push_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_pop_value;
  logic [1:0]         out_status;
  logic [7:0]         out_fill_count;

  deque_mirror mirror;
  logic        long_hold_req = 1'b0;
  int          cycle_count = 0;
  int          burst_left = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  bounded_deque_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pop_value  (out_pop_value),
    .out_status     (out_status),
    .out_fill_count (out_fill_count)
  );

  // results are checked before the same edge's request is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        mirror.check_result(out_pop_value, out_status, out_fill_count);
      if (in_valid && !in_stall)
        mirror.note_request(bdq_pkg::mode_t'(in_mode), in_push_value);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped by cycle limit, %0d words still owed",
               mirror.pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: segments of differing stall density, plus one long hold on request
  initial begin : rx_pattern
    int   seg_left;
    int   stall_pct;
    int   hold_left;
    logic hold_done;
    out_stall = 1'b0;
    seg_left  = 0;
    stall_pct = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 80);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(bdq_pkg::mode_t mode, bdq_pkg::word_t value);
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_push_value <= value;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_paced(bdq_pkg::mode_t mode, bdq_pkg::word_t value);
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(60, 200);
      end else begin
        idle_cycles($urandom_range(0, 6));
        burst_left = $urandom_range(1, 24);
      end
    end
    burst_left--;
    send_word(mode, value);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    @(negedge clk);
    while (mirror.pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic bdq_pkg::mode_t pick_mode(int push_pct);
    logic push;
    logic front;
    push  = ($urandom_range(0, 99) < push_pct);
    front = 1'($urandom_range(0, 1));
    if (push) return front ? bdq_pkg::MODE_PUSH_FRONT : bdq_pkg::MODE_PUSH_REAR;
    return front ? bdq_pkg::MODE_POP_FRONT : bdq_pkg::MODE_POP_REAR;
  endfunction

  function automatic bdq_pkg::word_t pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      4: return bdq_pkg::word_t'($urandom_range(0, 255));
      default: return bdq_pkg::word_t'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int          sent;
    int          phase;
    int          len;
    int          push_pct;
    phase_kind_t kind;
    mirror        = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = bdq_pkg::MODE_PUSH_FRONT;
    in_push_value = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // pops on an empty queue, extreme words at both ends, then empty it again
    send_word(bdq_pkg::MODE_POP_FRONT, 32'h1234_5678);
    send_word(bdq_pkg::MODE_POP_REAR, 32'hffff_ffff);
    send_word(bdq_pkg::MODE_PUSH_REAR, 32'h7fff_ffff);
    send_word(bdq_pkg::MODE_PUSH_FRONT, 32'h8000_0000);
    send_word(bdq_pkg::MODE_PUSH_REAR, 32'h0000_0000);
    send_word(bdq_pkg::MODE_PUSH_FRONT, 32'hffff_ffff);
    send_word(bdq_pkg::MODE_PUSH_REAR, 32'h5555_5555);
    send_word(bdq_pkg::MODE_PUSH_FRONT, 32'haaaa_aaaa);
    send_word(bdq_pkg::MODE_POP_FRONT, 32'h0);
    send_word(bdq_pkg::MODE_POP_REAR, 32'h0);
    send_word(bdq_pkg::MODE_POP_FRONT, 32'h0);
    send_word(bdq_pkg::MODE_POP_REAR, 32'h0);
    send_word(bdq_pkg::MODE_POP_REAR, 32'h0);
    send_word(bdq_pkg::MODE_POP_FRONT, 32'h0);
    send_word(bdq_pkg::MODE_POP_REAR, 32'hdead_beef);
    // head stays where it was once empty; the next pushes work from there
    send_word(bdq_pkg::MODE_PUSH_FRONT, 32'h0000_0001);
    send_word(bdq_pkg::MODE_POP_REAR, 32'h0);
    send_word(bdq_pkg::MODE_PUSH_REAR, 32'h0000_0002);
    send_word(bdq_pkg::MODE_POP_FRONT, 32'h0);
    send_word(bdq_pkg::MODE_POP_FRONT, 32'h0);
    drain_wait();

    // first a push-heavy fill phase then a pop-heavy drain phase, then random phases
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      kind = (phase < 2) ? phase_kind_t'(phase) : phase_kind_t'($urandom_range(0, 2));
      case (kind)
        PH_FILL: begin
          push_pct = 85;
          len      = $urandom_range(180, 260);
        end
        PH_DRAIN: begin
          push_pct = 15;
          len      = $urandom_range(180, 260);
        end
        default: begin
          push_pct = 50;
          len      = $urandom_range(40, 120);
        end
      endcase
      for (int i = 0; i < len && sent < RANDOM_WORDS; i++) begin
        // receiver holds off for a long stretch while words keep coming
        if (sent == RANDOM_WORDS / 2) long_hold_req = 1'b1;
        send_paced(pick_mode(push_pct), pick_value());
        sent++;
      end
      if (phase == 2 || $urandom_range(0, 3) == 0) drain_wait();
      phase++;
    end

    drain_wait();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("checked %0d results: %0d pushes, %0d pops, %0d refused full, %0d refused empty",
             mirror.checked, mirror.pushes, mirror.pops,
             mirror.full_refusals, mirror.empty_refusals);
    $display("peak fill %0d of %0d, %0d mismatches", mirror.peak_fill, bdq_pkg::CAPACITY,
             mirror.errors);
    if (mirror.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/bdq_pkg.sv
hdl/bdq_cell.sv
hdl/bdq_row.sv
hdl/bounded_deque_top.sv
tb/bounded_deque_top_test.sv
